// ===== rtl/cia_pkg.sv =====
// Package for the checked 64-bit ALU: opcodes, status codes, pipeline
// constants and the sideband struct that travels beside the datapath.
// No dependencies.
`default_nettype none
package cia_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_REM = 3'd5,
    OP_CMP = 3'd6,
    OP_NOP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_UNF  = 2'd2,
    ST_DIVZ = 2'd3
  } status_e;

  localparam int unsigned DataW     = 64;
  localparam int unsigned DivStages = DataW;
  localparam int unsigned MulStages = 3;
  // stages from the decode register to the final select
  localparam int unsigned CoreStages = DivStages;

  typedef struct packed {
    op_e              op;
    logic             sign_a;
    logic             sign_b;
    logic             div_zero;
    logic             div_ovf;
    logic             rem_m1;
    logic             mul_min;
    logic [DataW-1:0] simple_val;
    status_e          simple_st;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/cia_delay.sv =====
// Payload delay line with a common advance enable.
// Depends on nothing beyond its parameters.
`default_nettype none
module cia_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/cia_mul.sv =====
// Three-stage unsigned 64x64 multiplier built from four 32x32 partial products.
// Depends on cia_pkg.
`default_nettype none
module cia_mul import cia_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [DataW-1:0]   a_i,
  input  wire logic [DataW-1:0]   b_i,
  output logic      [2*DataW-1:0] prod_o
);

  localparam int unsigned HalfW = DataW / 2;

  logic [DataW-1:0]   pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [DataW-1:0]   lo_q, hi_q;
  logic [DataW:0]     mid_q;
  logic [2*DataW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= a_i[HalfW-1:0]     * b_i[HalfW-1:0];
      pp_lh_q <= a_i[HalfW-1:0]     * b_i[DataW-1:HalfW];
      pp_hl_q <= a_i[DataW-1:HalfW] * b_i[HalfW-1:0];
      pp_hh_q <= a_i[DataW-1:HalfW] * b_i[DataW-1:HalfW];
      lo_q    <= pp_ll_q;
      hi_q    <= pp_hh_q;
      mid_q   <= {1'b0, pp_lh_q} + {1'b0, pp_hl_q};
      prod_q  <= {hi_q, lo_q} + ({{(DataW-1){1'b0}}, mid_q} << HalfW);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== rtl/cia_divider.sv =====
// Restoring divider, one quotient bit per pipeline stage, fully pipelined.
// Depends on cia_pkg.
`default_nettype none
module cia_divider import cia_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output logic      [DataW-1:0] quo_o,
  output logic      [DataW-1:0] rem_o
);

  // stage i registers hold the partial remainder, quotient and divisor
  logic [DataW-1:0] rem_q [DivStages];
  logic [DataW-1:0] quo_q [DivStages];
  logic [DataW-1:0] den_q [DivStages];
  logic [DataW-1:0] rem_d [DivStages];
  logic [DataW-1:0] quo_d [DivStages];
  logic [DataW-1:0] den_d [DivStages];

  always_comb begin
    logic [DataW-1:0] r, rp, qp, dp;
    for (int i = 0; i < DivStages; i++) begin
      if (i == 0) begin
        rp = '0;
        qp = dividend_i;
        dp = divisor_i;
      end else begin
        rp = rem_q[i-1];
        qp = quo_q[i-1];
        dp = den_q[i-1];
      end
      den_d[i] = dp;
      // shift in the next dividend bit, subtract when it fits
      r = {rp[DataW-2:0], qp[DataW-1]};
      if (r >= dp) begin
        rem_d[i] = r - dp;
        quo_d[i] = {qp[DataW-2:0], 1'b1};
      end else begin
        rem_d[i] = r;
        quo_d[i] = {qp[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DivStages; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
        den_q[i] <= den_d[i];
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];
  assign rem_o = rem_q[DivStages-1];

endmodule
`default_nettype wire

// ===== rtl/checked_int64_alu.sv =====
// Signed 64-bit ALU that reports overflow, underflow and divide by zero
// instead of wrapping; an error forces the value to zero.
//
// Input channel s_axis: tuser carries op, tdata carries operand_a (low 64
// bits) and operand_b (high 64 bits). Output channel m_axis: tdata carries
// value, tuser carries status (0 ok, 1 overflow, 2 underflow, 3 divide by
// zero).
// Pipeline from an accepted beat to its result on m_axis: an operand
// register, a decode stage, 64 stages of the bit-per-stage divider (the
// longest unit; multiply and the simple ops are delayed to match) and the
// output register.
// Throughput: one beat per cycle. The whole pipeline advances together
// whenever the output register is empty or being taken; while the receiver
// stalls with a result waiting, s_axis_tready drops and every stage holds.
// Reset clears all valid bits; payload registers are not reset.
// Depends on cia_pkg, cia_divider, cia_mul and cia_delay.
`default_nettype none
module checked_int64_alu import cia_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // operand_a[63:0], operand_b[127:64]
  input  wire logic [2:0]   s_axis_tuser,  // op[2:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [63:0]  m_axis_tdata,  // value[63:0]
  output logic      [1:0]   m_axis_tuser   // status[1:0]
);

  localparam int unsigned VldStages = CoreStages + 2;

  logic                 en;
  logic [VldStages-1:0] vld_q;

  // operand register
  op_e              op_q;
  logic [DataW-1:0] a_q, b_q;

  // decode stage
  logic [DataW-1:0] ma_d, mb_d, ma_q, mb_q;
  side_t            side_d, side_q, side_end;

  logic [DataW-1:0]   quo, rem;
  logic [2*DataW-1:0] prod;
  logic [DataW:0]     mul_end;

  logic [DataW-1:0] val_d, val_q, mag;
  logic             neg;
  status_e          st_d, st_q;
  logic             out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[VldStages-2:0], s_axis_tvalid};
      out_v_q <= vld_q[VldStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= op_e'(s_axis_tuser);
      a_q  <= s_axis_tdata[DataW-1:0];
      b_q  <= s_axis_tdata[2*DataW-1:DataW];
    end
  end

  always_comb begin
    logic [DataW-1:0] sum, dif;
    logic             sa, sb;
    sa  = a_q[DataW-1];
    sb  = b_q[DataW-1];
    sum = a_q + b_q;
    dif = a_q - b_q;
    ma_d = sa ? (~a_q + 1'b1) : a_q;
    mb_d = sb ? (~b_q + 1'b1) : b_q;

    side_d            = '0;
    side_d.op         = op_q;
    side_d.sign_a     = sa;
    side_d.sign_b     = sb;
    side_d.div_zero   = (b_q == '0);
    side_d.div_ovf    = (a_q == {1'b1, {(DataW-1){1'b0}}}) && (b_q == '1);
    side_d.rem_m1     = (b_q == '1);
    side_d.mul_min    = (a_q == {1'b1, {(DataW-1){1'b0}}}) ||
                        (b_q == {1'b1, {(DataW-1){1'b0}}});
    side_d.simple_val = '0;
    side_d.simple_st  = ST_OK;
    unique case (op_q)
      OP_ADD: begin
        if (!sa && !sb && sum[DataW-1])      side_d.simple_st = ST_OVF;
        else if (sa && sb && !sum[DataW-1])  side_d.simple_st = ST_UNF;
        else                                 side_d.simple_val = sum;
      end
      OP_SUB: begin
        if (!sa && sb && dif[DataW-1])       side_d.simple_st = ST_OVF;
        else if (sa && !sb && !dif[DataW-1]) side_d.simple_st = ST_UNF;
        else                                 side_d.simple_val = dif;
      end
      OP_NEG: begin
        if (side_d.mul_min && sa && (a_q[DataW-2:0] == '0)) side_d.simple_st = ST_OVF;
        else side_d.simple_val = ~a_q + 1'b1;
      end
      OP_CMP: begin
        if ($signed(a_q) < $signed(b_q))      side_d.simple_val = '1;
        else if ($signed(a_q) > $signed(b_q)) side_d.simple_val = {{(DataW-1){1'b0}}, 1'b1};
        else                                  side_d.simple_val = '0;
      end
      default: side_d.simple_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      side_q <= side_d;
    end
  end

  cia_divider u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (ma_q),
    .divisor_i  (mb_q),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  cia_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (ma_q),
    .b_i    (mb_q),
    .prod_o (prod)
  );

  // align the product (with its range flag) to the divider output
  cia_delay #(
    .WIDTH (DataW + 1),
    .DEPTH (CoreStages - MulStages)
  ) u_mul_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({(prod[2*DataW-1:DataW-1] != '0), prod[DataW-1:0]}),
    .q_o   (mul_end)
  );

  cia_delay #(
    .WIDTH ($bits(side_t)),
    .DEPTH (CoreStages)
  ) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side_q),
    .q_o   (side_end)
  );

  always_comb begin
    mag   = '0;
    neg   = 1'b0;
    st_d  = ST_OK;
    val_d = '0;
    unique case (side_end.op)
      OP_MUL: begin
        if (side_end.mul_min || mul_end[DataW]) st_d = ST_OVF;
        else begin
          mag = mul_end[DataW-1:0];
          neg = side_end.sign_a ^ side_end.sign_b;
        end
      end
      OP_DIV: begin
        if (side_end.div_zero)     st_d = ST_DIVZ;
        else if (side_end.div_ovf) st_d = ST_OVF;
        else begin
          mag = quo;
          neg = side_end.sign_a ^ side_end.sign_b;
        end
      end
      OP_REM: begin
        if (side_end.div_zero)     st_d = ST_DIVZ;
        else if (!side_end.rem_m1) begin
          mag = rem;
          neg = side_end.sign_a;
        end
      end
      OP_NOP: st_d = ST_OK;
      default: st_d = side_end.simple_st;
    endcase
    if (side_end.op == OP_ADD || side_end.op == OP_SUB ||
        side_end.op == OP_NEG || side_end.op == OP_CMP) begin
      val_d = side_end.simple_val;
    end else begin
      val_d = neg ? (~mag + 1'b1) : mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      st_q  <= st_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = val_q;
  assign m_axis_tuser  = st_q;

  // any reported error carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
    else $error("error result with nonzero value");

  // a stalled result blocks the input side
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // a result appears only after a full pipeline of accepted work
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[VldStages-1]))
    else $error("result without a matching item");

endmodule
`default_nettype wire
